[hdl/psnc_pkg.sv]
// Shared constants, types and command codes for the pruned shortest-path block.
// No dependencies; every other file of the block uses this package.
package psnc_pkg;

    localparam int MaxNodes = 2048;
    localparam int MaxEdges = 4096;
    localparam int VW       = $clog2(MaxNodes);   // vertex index width
    localparam int EW       = $clog2(MaxEdges);   // edge index width
    localparam int LW       = EW + 1;             // list link width, zero ends a list
    localparam int DW       = 32;                 // distance width
    localparam int CW       = 12;                 // enqueue count width
    localparam int WW       = 17;                 // edge weight width
    localparam int NCW      = 12;                 // node_count register width
    localparam int PW       = 16;                 // penalty and reward width
    localparam int SW       = 28;                 // score width
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 16;

    localparam logic [SW-1:0]     SCORE_MAX      = '1;
    localparam logic [CFG_IW-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_PENALTY    = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD_RD,
        OP_LOAD_WR,
        OP_MK_INIT,
        OP_MK_POP,
        OP_MK_HEAD,
        OP_MK_LINK,
        OP_MK_EDGE,
        OP_MK_SRC,
        OP_MK_CHK,
        OP_RX_INIT,
        OP_RX_INIT2,
        OP_RX_POP,
        OP_RX_U,
        OP_RX_U2,
        OP_RX_LINK,
        OP_RX_EDGE,
        OP_RX_TGT,
        OP_RX_CHK,
        OP_DONE_RD,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic clr_last;
        logic sp_zero;
        logic e_zero;
        logic s_ok;
        logic v_ok;
        logic qn_zero;
        logic hit;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic                 reach;
        logic                 dvalid;
        logic                 inq;
        logic [CW-1:0]        cnt;
        logic signed [DW-1:0] path_cost;
    } vinfo_t;

    typedef struct packed {
        logic [VW-1:0]        tgt;
        logic signed [WW-1:0] weight;
        logic [LW-1:0]        next;
    } fwd_t;

    typedef struct packed {
        logic [VW-1:0] src;
        logic [LW-1:0] next;
    } rev_t;

endpackage

[hdl/psnc_if.sv]
// Handshake interfaces for the edge input, result output and configuration write channels.
// Depends on psnc_pkg for field widths.
interface psnc_edge_if;
    logic                      valid;
    logic                      ready;
    logic [psnc_pkg::NCW-1:0]  src_vertex;
    logic [psnc_pkg::NCW-1:0]  dst_vertex;
    logic [psnc_pkg::PW-1:0]   reward;
    logic                      last_edge;

    modport source (output valid, src_vertex, dst_vertex, reward, last_edge, input ready);
    modport sink   (input valid, src_vertex, dst_vertex, reward, last_edge, output ready);
endinterface

interface psnc_result_if;
    logic                     valid;
    logic                     ready;
    logic [psnc_pkg::SW-1:0]  best_score;
    logic                     neg_cycle;

    modport source (output valid, best_score, neg_cycle, input ready);
    modport sink   (input valid, best_score, neg_cycle, output ready);
endinterface

interface psnc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [psnc_pkg::CFG_IW-1:0]  index;
    logic [psnc_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/pruned_spfa_negative_cycle.sv]
// Channel      | Direction | Payload
// edges        | in        | src_vertex, dst_vertex, reward, last_edge
// result       | out       | best_score, neg_cycle (one transaction per run)
// cfg          | in        | index (0 node_count, 1 penalty), data
//
// Each edge is loaded as a head-pointer read, then the list insert; no edge is taken
// during the insert. After the last edge, marking pops each vertex off the stack and walks
// its reverse edges, and relaxation dequeues each vertex and walks its forward edges. After
// reset and after every result a clearing pass over all 2048 entries empties the vertex
// stores; no edge is accepted then. A waiting result does not stop the next edges loading.
module pruned_spfa_negative_cycle (
    input logic           clk,
    input logic           rst_n,
    psnc_edge_if.sink     edges,
    psnc_result_if.source result,
    psnc_cfg_if.sink      cfg
);
    import psnc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psnc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    psnc_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .edges  (edges),
        .result (result),
        .cfg    (cfg)
    );

endmodule

[hdl/psnc_ctrl.sv]
// Sequencer for clearing, loading, reachability marking, relaxation and result delivery.
// Depends on psnc_pkg for the command and status structs.
module psnc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  psnc_pkg::stat_t stat,
    output psnc_pkg::cmd_t  cmd
);
    import psnc_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_LDWR    = 5'd2;
    localparam logic [4:0] S_MKINIT  = 5'd3;
    localparam logic [4:0] S_MKPOP   = 5'd4;
    localparam logic [4:0] S_MKHEAD  = 5'd5;
    localparam logic [4:0] S_MKLINK  = 5'd6;
    localparam logic [4:0] S_MKEDGE  = 5'd7;
    localparam logic [4:0] S_MKSRC   = 5'd8;
    localparam logic [4:0] S_MKCHK   = 5'd9;
    localparam logic [4:0] S_RXINIT  = 5'd10;
    localparam logic [4:0] S_RXINIT2 = 5'd11;
    localparam logic [4:0] S_RXPOP   = 5'd12;
    localparam logic [4:0] S_RXU     = 5'd13;
    localparam logic [4:0] S_RXU2    = 5'd14;
    localparam logic [4:0] S_RXLINK  = 5'd15;
    localparam logic [4:0] S_RXEDGE  = 5'd16;
    localparam logic [4:0] S_RXTGT   = 5'd17;
    localparam logic [4:0] S_RXCHK   = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;
    localparam logic [4:0] S_RES     = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.op     = OP_LOAD_RD;
                    state_next = S_LDWR;
                end
            end
            S_LDWR:
            begin
                cmd.op     = OP_LOAD_WR;
                state_next = stat.last ? S_MKINIT : S_IDLE;
            end
            S_MKINIT:
            begin
                cmd.op     = OP_MK_INIT;
                state_next = S_MKPOP;
            end
            S_MKPOP:
            begin
                if (stat.sp_zero)
                begin
                    state_next = S_RXINIT;
                end
                else
                begin
                    cmd.op     = OP_MK_POP;
                    state_next = S_MKHEAD;
                end
            end
            S_MKHEAD:
            begin
                cmd.op     = OP_MK_HEAD;
                state_next = S_MKLINK;
            end
            S_MKLINK:
            begin
                cmd.op     = OP_MK_LINK;
                state_next = S_MKEDGE;
            end
            S_MKEDGE:
            begin
                if (stat.e_zero)
                begin
                    state_next = S_MKPOP;
                end
                else
                begin
                    cmd.op     = OP_MK_EDGE;
                    state_next = S_MKSRC;
                end
            end
            S_MKSRC:
            begin
                cmd.op     = OP_MK_SRC;
                state_next = stat.s_ok ? S_MKCHK : S_MKEDGE;
            end
            S_MKCHK:
            begin
                cmd.op     = OP_MK_CHK;
                state_next = S_MKEDGE;
            end
            S_RXINIT:
            begin
                cmd.op     = OP_RX_INIT;
                state_next = S_RXINIT2;
            end
            S_RXINIT2:
            begin
                cmd.op     = OP_RX_INIT2;
                state_next = S_RXPOP;
            end
            S_RXPOP:
            begin
                if (stat.qn_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RX_POP;
                    state_next = S_RXU;
                end
            end
            S_RXU:
            begin
                cmd.op     = OP_RX_U;
                state_next = S_RXU2;
            end
            S_RXU2:
            begin
                cmd.op     = OP_RX_U2;
                state_next = S_RXLINK;
            end
            S_RXLINK:
            begin
                cmd.op     = OP_RX_LINK;
                state_next = S_RXEDGE;
            end
            S_RXEDGE:
            begin
                if (stat.e_zero)
                begin
                    state_next = S_RXPOP;
                end
                else
                begin
                    cmd.op     = OP_RX_EDGE;
                    state_next = S_RXTGT;
                end
            end
            S_RXTGT:
            begin
                cmd.op     = OP_RX_TGT;
                state_next = stat.v_ok ? S_RXCHK : S_RXEDGE;
            end
            S_RXCHK:
            begin
                cmd.op     = OP_RX_CHK;
                state_next = stat.hit ? S_DONE : S_RXEDGE;
            end
            S_DONE:
            begin
                cmd.op     = OP_DONE_RD;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_CLR;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

[hdl/psnc_datapath.sv]
// Graph stores, walk stack, work queue, relaxation arithmetic and the result register.
// Depends on psnc_pkg and the channel interfaces in psnc_if.sv.
module psnc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  psnc_pkg::cmd_t  cmd,
    output psnc_pkg::stat_t stat,
    psnc_edge_if.sink       edges,
    psnc_result_if.source   result,
    psnc_cfg_if.sink        cfg
);
    import psnc_pkg::*;

    // Memories
    logic [LW-1:0] hf_mem [MaxNodes];
    logic [LW-1:0] hr_mem [MaxNodes];
    fwd_t          fe_mem [MaxEdges];
    rev_t          re_mem [MaxEdges];
    vinfo_t        vi_mem [MaxNodes];
    logic [VW-1:0] q_mem  [MaxNodes];
    logic [VW-1:0] st_mem [MaxNodes];

    logic [LW-1:0] hf_rdata, hr_rdata, hf_wdata, hr_wdata;
    logic [VW-1:0] hf_raddr, hr_raddr, hf_waddr, hr_waddr;
    logic          hf_re, hr_re, hf_we, hr_we;
    fwd_t          fe_rdata, fe_wdata;
    rev_t          re_rdata, re_wdata;
    logic [EW-1:0] fe_raddr, re_raddr, e_waddr;
    logic          fe_re, re_re, e_we;
    vinfo_t        vi_rdata, vi_wdata;
    logic [VW-1:0] vi_raddr, vi_waddr;
    logic          vi_re, vi_we;
    logic [VW-1:0] q_rdata, q_wdata, q_waddr;
    logic          q_re, q_we;
    logic [VW-1:0] st_rdata, st_wdata, st_waddr, st_raddr;
    logic          st_re, st_we;

    // Control registers
    logic [NCW-1:0] node_count_reg;
    logic [PW-1:0]  penalty_reg;
    logic [VW-1:0]  clr_idx_reg;
    logic [EW:0]    edge_total_reg;
    logic           last_reg;
    logic           ok_reg;
    logic [VW:0]    sp_reg;
    logic [VW-1:0]  qh_reg, qt_reg;
    logic [VW:0]    qn_reg;
    logic           neg_reg;
    logic           out_valid_reg;

    // Payload registers
    logic [VW-1:0]        src_reg, dst_reg, s_reg, u_reg, v_reg;
    logic [PW-1:0]        rew_reg;
    logic [LW-1:0]        e_reg;
    logic signed [DW-1:0] du_reg, cand_reg;
    logic [SW-1:0]        score_reg;
    logic                 negout_reg;

    logic [VW:0]          n_val;
    logic [VW-1:0]        tgt;
    logic                 in_ok;
    logic [VW-1:0]        s_in, d_in;
    logic                 s_ok, v_ok;
    logic                 upd, enq, hit;
    logic [CW-1:0]        newcnt;
    logic signed [DW-1:0] neg_dist;
    logic [SW-1:0]        score_val;
    logic                 out_free;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_val = (VW+1)'(1);
        end
        else if (node_count_reg > NCW'(MaxNodes))
        begin
            n_val = (VW+1)'(MaxNodes);
        end
        else
        begin
            n_val = (VW+1)'(node_count_reg);
        end
    end
    assign tgt = VW'(n_val - (VW+1)'(1));

    assign in_ok = (edges.src_vertex != '0) && (edges.src_vertex <= NCW'(MaxNodes))
                && (edges.dst_vertex != '0) && (edges.dst_vertex <= NCW'(MaxNodes))
                && !edge_total_reg[EW];
    assign s_in  = VW'(edges.src_vertex - NCW'(1));
    assign d_in  = VW'(edges.dst_vertex - NCW'(1));

    assign s_ok = {1'b0, re_rdata.src} < n_val;
    assign v_ok = {1'b0, fe_rdata.tgt} < n_val;

    // Relaxation decision for the target just read.
    assign upd    = vi_rdata.reach
                 && (!vi_rdata.dvalid || (cand_reg < vi_rdata.path_cost));
    assign enq    = upd && !vi_rdata.inq && !qn_reg[VW];
    assign newcnt = vi_rdata.cnt + CW'(enq);
    assign hit    = upd && (n_val <= newcnt);

    assign neg_dist = -vi_rdata.path_cost;
    always_comb
    begin
        score_val = '0;
        if (!neg_reg && vi_rdata.dvalid && (vi_rdata.path_cost < 0))
        begin
            if (neg_dist > DW'(SCORE_MAX))
            begin
                score_val = SCORE_MAX;
            end
            else
            begin
                score_val = neg_dist[SW-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    assign stat.in_valid = edges.valid;
    assign stat.last     = last_reg;
    assign stat.clr_last = (clr_idx_reg == '1);
    assign stat.sp_zero  = (sp_reg == '0);
    assign stat.e_zero   = (e_reg == '0);
    assign stat.s_ok     = s_ok;
    assign stat.v_ok     = v_ok;
    assign stat.qn_zero  = (qn_reg == '0);
    assign stat.hit      = hit;
    assign stat.out_free = out_free;

    assign edges.ready       = cmd.in_ready;
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.best_score = score_reg;
    assign result.neg_cycle  = negout_reg;

    // Memory port selection
    always_comb
    begin
        hf_re = 1'b0; hf_raddr = s_in;  hf_we = 1'b0; hf_waddr = clr_idx_reg; hf_wdata = '0;
        hr_re = 1'b0; hr_raddr = d_in;  hr_we = 1'b0; hr_waddr = clr_idx_reg; hr_wdata = '0;
        fe_re = 1'b0; fe_raddr = EW'(e_reg - LW'(1));
        re_re = 1'b0; re_raddr = EW'(e_reg - LW'(1));
        e_we  = 1'b0; e_waddr  = edge_total_reg[EW-1:0];
        fe_wdata.tgt    = dst_reg;
        fe_wdata.weight = WW'({1'b0, penalty_reg}) - WW'({1'b0, rew_reg});
        fe_wdata.next   = hf_rdata;
        re_wdata.src    = src_reg;
        re_wdata.next   = hr_rdata;
        vi_re = 1'b0; vi_raddr = tgt; vi_we = 1'b0; vi_waddr = clr_idx_reg; vi_wdata = '0;
        q_re  = 1'b0; q_we = 1'b0; q_waddr = qt_reg; q_wdata = v_reg;
        st_re = 1'b0; st_raddr = VW'(sp_reg - (VW+1)'(1));
        st_we = 1'b0; st_waddr = sp_reg[VW-1:0]; st_wdata = s_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                hf_we = 1'b1;
                hr_we = 1'b1;
                vi_we = 1'b1;
            end
            OP_LOAD_RD:
            begin
                hf_re = 1'b1;
                hr_re = 1'b1;
            end
            OP_LOAD_WR:
            begin
                hf_we    = ok_reg;
                hf_waddr = src_reg;
                hf_wdata = LW'(edge_total_reg) + LW'(1);
                hr_we    = ok_reg;
                hr_waddr = dst_reg;
                hr_wdata = LW'(edge_total_reg) + LW'(1);
                e_we     = ok_reg;
            end
            OP_MK_INIT:
            begin
                vi_we          = 1'b1;
                vi_waddr       = tgt;
                vi_wdata.reach = 1'b1;
                st_we          = 1'b1;
                st_waddr       = '0;
                st_wdata       = tgt;
            end
            OP_MK_POP:
            begin
                st_re = 1'b1;
            end
            OP_MK_HEAD:
            begin
                hr_re    = 1'b1;
                hr_raddr = st_rdata;
            end
            OP_MK_EDGE:
            begin
                re_re = 1'b1;
            end
            OP_MK_SRC:
            begin
                vi_re    = s_ok;
                vi_raddr = re_rdata.src;
            end
            OP_MK_CHK:
            begin
                vi_we          = !vi_rdata.reach && !sp_reg[VW];
                vi_waddr       = s_reg;
                vi_wdata       = vi_rdata;
                vi_wdata.reach = 1'b1;
                st_we          = !vi_rdata.reach && !sp_reg[VW];
            end
            OP_RX_INIT:
            begin
                vi_re    = 1'b1;
                vi_raddr = '0;
            end
            OP_RX_INIT2:
            begin
                vi_we              = 1'b1;
                vi_waddr           = '0;
                vi_wdata           = vi_rdata;
                vi_wdata.dvalid    = 1'b1;
                vi_wdata.inq       = 1'b1;
                vi_wdata.cnt       = CW'(1);
                vi_wdata.path_cost = '0;
                q_we               = 1'b1;
                q_waddr            = '0;
                q_wdata            = '0;
            end
            OP_RX_POP:
            begin
                q_re = 1'b1;
            end
            OP_RX_U:
            begin
                vi_re    = 1'b1;
                vi_raddr = q_rdata;
            end
            OP_RX_U2:
            begin
                vi_we        = 1'b1;
                vi_waddr     = u_reg;
                vi_wdata     = vi_rdata;
                vi_wdata.inq = 1'b0;
                hf_re        = 1'b1;
                hf_raddr     = u_reg;
            end
            OP_RX_EDGE:
            begin
                fe_re = 1'b1;
            end
            OP_RX_TGT:
            begin
                vi_re    = v_ok;
                vi_raddr = fe_rdata.tgt;
            end
            OP_RX_CHK:
            begin
                vi_we              = upd;
                vi_waddr           = v_reg;
                vi_wdata.reach     = 1'b1;
                vi_wdata.dvalid    = 1'b1;
                vi_wdata.inq       = vi_rdata.inq || enq;
                vi_wdata.cnt       = newcnt;
                vi_wdata.path_cost = cand_reg;
                q_we               = enq;
            end
            OP_DONE_RD:
            begin
                vi_re    = 1'b1;
                vi_raddr = tgt;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hf_we) hf_mem[hf_waddr] <= hf_wdata;
        if (hf_re) hf_rdata <= hf_mem[hf_raddr];
        if (hr_we) hr_mem[hr_waddr] <= hr_wdata;
        if (hr_re) hr_rdata <= hr_mem[hr_raddr];
        if (e_we)  fe_mem[e_waddr] <= fe_wdata;
        if (fe_re) fe_rdata <= fe_mem[fe_raddr];
        if (e_we)  re_mem[e_waddr] <= re_wdata;
        if (re_re) re_rdata <= re_mem[re_raddr];
        if (vi_we) vi_mem[vi_waddr] <= vi_wdata;
        if (vi_re) vi_rdata <= vi_mem[vi_raddr];
        if (q_we)  q_mem[q_waddr] <= q_wdata;
        if (q_re)  q_rdata <= q_mem[qh_reg];
        if (st_we) st_mem[st_waddr] <= st_wdata;
        if (st_re) st_rdata <= st_mem[st_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NCW'(2);
            penalty_reg    <= '0;
            clr_idx_reg    <= '0;
            edge_total_reg <= '0;
            last_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            sp_reg         <= '0;
            qh_reg         <= '0;
            qt_reg         <= '0;
            qn_reg         <= '0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_NODE_COUNT: node_count_reg <= cfg.data[NCW-1:0];
                    CFG_PENALTY:    penalty_reg    <= cfg.data[PW-1:0];
                    default:        node_count_reg <= node_count_reg;
                endcase
            end
            if (cmd.op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    clr_idx_reg    <= clr_idx_reg + VW'(1);
                    edge_total_reg <= '0;
                end
                OP_LOAD_RD:
                begin
                    last_reg <= edges.last_edge;
                    ok_reg   <= in_ok;
                end
                OP_LOAD_WR:
                begin
                    if (ok_reg)
                    begin
                        edge_total_reg <= edge_total_reg + (EW+1)'(1);
                    end
                end
                OP_MK_INIT:
                begin
                    sp_reg  <= (VW+1)'(1);
                    neg_reg <= 1'b0;
                end
                OP_MK_POP:
                begin
                    sp_reg <= sp_reg - (VW+1)'(1);
                end
                OP_MK_CHK:
                begin
                    if (!vi_rdata.reach && !sp_reg[VW])
                    begin
                        sp_reg <= sp_reg + (VW+1)'(1);
                    end
                end
                OP_RX_INIT2:
                begin
                    qh_reg <= '0;
                    qt_reg <= VW'(1);
                    qn_reg <= (VW+1)'(1);
                end
                OP_RX_POP:
                begin
                    qh_reg <= qh_reg + VW'(1);
                    qn_reg <= qn_reg - (VW+1)'(1);
                end
                OP_RX_CHK:
                begin
                    if (enq)
                    begin
                        qt_reg <= qt_reg + VW'(1);
                        qn_reg <= qn_reg + (VW+1)'(1);
                    end
                    if (hit)
                    begin
                        neg_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD_RD:
            begin
                src_reg <= s_in;
                dst_reg <= d_in;
                rew_reg <= edges.reward;
            end
            OP_MK_LINK:
            begin
                e_reg <= hr_rdata;
            end
            OP_MK_SRC:
            begin
                s_reg <= re_rdata.src;
                e_reg <= re_rdata.next;
            end
            OP_RX_U:
            begin
                u_reg <= q_rdata;
            end
            OP_RX_U2:
            begin
                du_reg <= vi_rdata.path_cost;
            end
            OP_RX_LINK:
            begin
                e_reg <= hf_rdata;
            end
            OP_RX_TGT:
            begin
                v_reg    <= fe_rdata.tgt;
                e_reg    <= fe_rdata.next;
                cand_reg <= du_reg + DW'(fe_rdata.weight);
            end
            OP_RX_CHK:
            begin
                // A self loop that improves the vertex being scanned feeds later edges.
                if (upd && (v_reg == u_reg))
                begin
                    du_reg <= cand_reg;
                end
            end
            OP_RESULT:
            begin
                score_reg  <= score_val;
                negout_reg <= neg_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hdl/psnc_checker.sv]
// Port-level checks for the pruned shortest-path block, bound to its top level.
// Depends on psnc_pkg for widths.
module psnc_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_last,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [psnc_pkg::SW-1:0]  best_score,
    input logic                     neg_cycle
);
    import psnc_pkg::*;

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before its transaction");

    // A negative cycle always reports a zero score.
    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && neg_cycle |-> best_score == '0)
        else $error("negative cycle with non-zero score");

    // An edge that is not the last one never produces a result.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last |=> !$rose(out_valid))
        else $error("result raised by an intermediate edge");

    // No edge is accepted while the list insert of the last one runs.
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("edge accepted in consecutive cycles");

endmodule

bind pruned_spfa_negative_cycle psnc_checker u_psnc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (edges.valid),
    .in_ready   (edges.ready),
    .in_last    (edges.last_edge),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .best_score (result.best_score),
    .neg_cycle  (result.neg_cycle)
);

[test/tb.sv]
// Self-checking bench for pruned_spfa_negative_cycle: edge runs in, one score per run out.
// Depends on psnc_pkg and the psnc_edge_if, psnc_result_if and psnc_cfg_if interfaces.
`timescale 1ns / 1ps

module tb;
    import psnc_pkg::*;

    typedef struct packed {
        logic [NCW-1:0] src;
        logic [NCW-1:0] dst;
        logic [PW-1:0]  reward;
        logic           last;
    } edge_item_t;

    typedef struct packed {
        logic [SW-1:0] score;
        logic          neg;
    } score_t;

    localparam int CLEAR_WAIT = 2100;
    localparam longint CYCLE_LIMIT = 64'd40000000;

    logic clk;
    logic rst_n;

    psnc_edge_if   edges_ch ();
    psnc_result_if res_ch ();
    psnc_cfg_if    cfg_ch ();

    pruned_spfa_negative_cycle uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .edges  (edges_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Graph store and search state of the predictor.
    int unsigned g_tgt[MaxEdges];
    int unsigned g_src[MaxEdges];
    int          g_wt[MaxEdges];
    int unsigned g_nxf[MaxEdges];
    int unsigned g_nxr[MaxEdges];
    int unsigned g_hdf[MaxNodes];
    int unsigned g_hdr[MaxNodes];
    int unsigned g_edges;
    bit          g_reach[MaxNodes];
    bit          g_dv[MaxNodes];
    bit          g_inq[MaxNodes];
    longint      g_dist[MaxNodes];
    int unsigned g_cnt[MaxNodes];
    int unsigned g_wq[MaxNodes];
    int unsigned g_stk[MaxNodes];
    int unsigned node_count_reg;
    int unsigned penalty_reg;

    edge_item_t  pending_edges[$];
    score_t      score_q[$];
    edge_item_t  cur_edge;
    bit          holding;
    bit          edge_fired;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          errors;
    int          runs_done;
    int          neg_seen;
    int          edges_sent;
    longint      cycles;

    function automatic bit relax_finds_cycle(input int unsigned n);
        int unsigned qh, qt, qn, u, e, v;
        longint cand;
        qh = 0;
        qt = 0;
        foreach (g_dv[i])
        begin
            g_dv[i] = 0;
            g_inq[i] = 0;
            g_cnt[i] = 0;
        end
        g_dist[0] = 0;
        g_dv[0] = 1;
        g_inq[0] = 1;
        g_cnt[0] = 1;
        g_wq[qt] = 0;
        qt = (qt + 1) % MaxNodes;
        qn = 1;
        while (qn > 0)
        begin
            u = g_wq[qh];
            qh = (qh + 1) % MaxNodes;
            qn--;
            g_inq[u] = 0;
            e = g_hdf[u];
            while (e != 0)
            begin
                v = g_tgt[e - 1];
                if (v < n && g_reach[v])
                begin
                    cand = g_dist[u] + longint'(g_wt[e - 1]);
                    if (!g_dv[v] || cand < g_dist[v])
                    begin
                        g_dist[v] = cand;
                        g_dv[v] = 1;
                        if (!g_inq[v] && qn < MaxNodes)
                        begin
                            g_inq[v] = 1;
                            g_wq[qt] = v;
                            qt = (qt + 1) % MaxNodes;
                            qn++;
                            g_cnt[v]++;
                        end
                        if (g_cnt[v] >= n)
                            return 1;
                    end
                end
                e = g_nxf[e - 1];
            end
        end
        return 0;
    endfunction

    // Stores an in-range edge; on a run's final edge, queues the expected score and clears the graph.
    task automatic absorb_edge(input edge_item_t it);
        int unsigned s, d, k, n, tgt, sp, x, e;
        score_t res;
        longint sc;
        s = it.src;
        d = it.dst;
        if (s >= 1 && s <= MaxNodes && d >= 1 && d <= MaxNodes && g_edges < MaxEdges)
        begin
            k = g_edges;
            g_tgt[k] = d - 1;
            g_src[k] = s - 1;
            g_wt[k] = int'(penalty_reg) - int'(it.reward);
            g_nxf[k] = g_hdf[s - 1];
            g_hdf[s - 1] = k + 1;
            g_nxr[k] = g_hdr[d - 1];
            g_hdr[d - 1] = k + 1;
            g_edges = k + 1;
        end
        if (it.last)
        begin
            n = node_count_reg;
            if (n < 1)
                n = 1;
            if (n > MaxNodes)
                n = MaxNodes;
            tgt = n - 1;
            foreach (g_reach[i])
                g_reach[i] = 0;
            g_reach[tgt] = 1;
            g_stk[0] = tgt;
            sp = 1;
            while (sp > 0)
            begin
                sp--;
                x = g_stk[sp];
                e = g_hdr[x];
                while (e != 0)
                begin
                    s = g_src[e - 1];
                    if (s < n && !g_reach[s] && sp < MaxNodes)
                    begin
                        g_reach[s] = 1;
                        g_stk[sp] = s;
                        sp++;
                    end
                    e = g_nxr[e - 1];
                end
            end
            res.score = '0;
            res.neg = 1'b0;
            if (relax_finds_cycle(n))
                res.neg = 1'b1;
            else if (g_dv[tgt] && g_dist[tgt] < 0)
            begin
                sc = -g_dist[tgt];
                if (sc > longint'(SCORE_MAX))
                    sc = longint'(SCORE_MAX);
                res.score = sc[SW-1:0];
            end
            score_q.push_back(res);
            foreach (g_hdf[i])
            begin
                g_hdf[i] = 0;
                g_hdr[i] = 0;
            end
            g_edges = 0;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Input and configuration acceptance, result checking and the cycle limit, all on the rising edge.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            if (rst_n && edges_ch.valid && edges_ch.ready)
            begin
                absorb_edge(cur_edge);
                edge_fired = 1;
                edges_sent++;
            end
            if (rst_n && cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_NODE_COUNT)
                    node_count_reg = cfg_ch.data[NCW-1:0];
                else
                    penalty_reg = cfg_ch.data;
            end
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (score_q.size() == 0)
                begin
                    $error("Result transaction with no score expected");
                    errors++;
                end
                else
                begin
                    if (res_ch.best_score !== score_q[0].score)
                    begin
                        $error("best_score: expected %0d, actual %0d",
                               score_q[0].score, res_ch.best_score);
                        errors++;
                    end
                    if (res_ch.neg_cycle !== score_q[0].neg)
                    begin
                        $error("neg_cycle: expected %0d, actual %0d",
                               score_q[0].neg, res_ch.neg_cycle);
                        errors++;
                    end
                    if (score_q[0].neg)
                        neg_seen++;
                    void'(score_q.pop_front());
                    runs_done++;
                end
            end
        end
    end

    // Edge driver: bursts of offers separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (edge_fired)
            begin
                edge_fired = 0;
                holding = 0;
                void'(pending_edges.pop_front());
            end
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_edges.size() > 0)
                begin
                    cur_edge = pending_edges[0];
                    holding = 1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            edges_ch.valid <= holding;
            edges_ch.src_vertex <= cur_edge.src;
            edges_ch.dst_vertex <= cur_edge.dst;
            edges_ch.reward <= cur_edge.reward;
            edges_ch.last_edge <= cur_edge.last;
        end
    end

    // Result receiver: ready follows one of four stall patterns, picked anew at random.
    always @(negedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 1) == 1);
            2: res_ch.ready <= (cycles % 8 < 3);
            default: res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every pending edge is taken and every score has arrived, then lets the
    // clearing pass finish so that the block is idle.
    task automatic drain_and_settle();
        do
            @(posedge clk);
        while (pending_edges.size() != 0 || holding || score_q.size() != 0);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic set_graph_regs(input int unsigned n, input int unsigned pen);
        write_reg(CFG_NODE_COUNT, {4'($urandom_range(0, 15)), 12'(n)});
        write_reg(CFG_PENALTY, 16'(pen));
    endtask

    function automatic edge_item_t mk_edge(input int unsigned s, input int unsigned d,
                                           input int unsigned r, input bit l);
        edge_item_t it;
        it.src = NCW'(s);
        it.dst = NCW'(d);
        it.reward = PW'(r);
        it.last = l;
        return it;
    endfunction

    function automatic int unsigned near_reward(input int unsigned pen);
        int r;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        r = int'(pen) + $urandom_range(0, 40) - 15;
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        return r;
    endfunction

    // Queues one run; a well-formed run holds a path from vertex 1 to the target.
    task automatic queue_run(input int unsigned n, input int unsigned pen, input bit well,
                             output int cnt);
        edge_item_t run[$];
        int unsigned v, w, extra;
        if (well)
        begin
            v = 1;
            while (v != n)
            begin
                w = ($urandom_range(0, 2) == 0) ? n : $urandom_range(2, n);
                run.push_back(mk_edge(v, w, near_reward(pen), 0));
                v = w;
            end
        end
        extra = $urandom_range(0, 8);
        repeat (extra)
            run.push_back(mk_edge($urandom_range(1, n + 2), $urandom_range(1, n + 2),
                                  near_reward(pen), 0));
        if ($urandom_range(0, 3) == 0)
            run.push_back(mk_edge($urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 65535), 0));
        if (run.size() == 0)
            run.push_back(mk_edge(1, n, near_reward(pen), 0));
        run.shuffle();
        run[run.size() - 1].last = 1'b1;
        cnt = run.size();
        foreach (run[i])
            pending_edges.push_back(run[i]);
    endtask

    initial
    begin
        int unsigned n, pen;
        int cnt, phase_items;

        rst_n = 1'b0;
        edges_ch.valid = 1'b0;
        edges_ch.src_vertex = '0;
        edges_ch.dst_vertex = '0;
        edges_ch.reward = '0;
        edges_ch.last_edge = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        node_count_reg = 2;
        penalty_reg = 0;
        g_edges = 0;
        foreach (g_hdf[i])
        begin
            g_hdf[i] = 0;
            g_hdr[i] = 0;
        end
        holding = 0;
        edge_fired = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        errors = 0;
        runs_done = 0;
        neg_seen = 0;
        edges_sent = 0;
        cycles = 0;
        cur_edge = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (CLEAR_WAIT) @(posedge clk);

        // Reset values: two vertices, no penalty.
        pending_edges.push_back(mk_edge(1, 2, 5, 1));
        drain_and_settle();

        // Out-of-range vertices are dropped; the last flag still ends the run.
        set_graph_regs(4, 10);
        pending_edges.push_back(mk_edge(1, 2, 0, 0));
        pending_edges.push_back(mk_edge(2, 4, 65535, 0));
        pending_edges.push_back(mk_edge(0, 3, 100, 0));
        pending_edges.push_back(mk_edge(4095, 1, 100, 0));
        pending_edges.push_back(mk_edge(1, 2049, 100, 1));
        pending_edges.push_back(mk_edge(1, 2, 0, 1));
        drain_and_settle();

        // A negative cycle on the path, and a penalty at its top value.
        set_graph_regs(3, 10);
        pending_edges.push_back(mk_edge(1, 2, 20, 0));
        pending_edges.push_back(mk_edge(2, 1, 20, 0));
        pending_edges.push_back(mk_edge(2, 3, 30, 1));
        drain_and_settle();
        set_graph_regs(3, 65535);
        pending_edges.push_back(mk_edge(1, 2, 0, 0));
        pending_edges.push_back(mk_edge(2, 3, 65535, 1));
        drain_and_settle();

        // Node counts of zero and one act as a single vertex.
        set_graph_regs(0, 5);
        pending_edges.push_back(mk_edge(1, 1, 9, 1));
        drain_and_settle();
        set_graph_regs(1, 5);
        pending_edges.push_back(mk_edge(1, 1, 2, 0));
        pending_edges.push_back(mk_edge(1, 2, 9, 1));
        drain_and_settle();

        // The largest graph, once through saturation of the node count.
        set_graph_regs(4095, 0);
        pending_edges.push_back(mk_edge(1, 2048, 700, 0));
        pending_edges.push_back(mk_edge(2048, 2048, 0, 1));
        drain_and_settle();
        set_graph_regs(2048, 3);
        pending_edges.push_back(mk_edge(1, 2048, 700, 0));
        pending_edges.push_back(mk_edge(2048, 2048, 4, 1));
        drain_and_settle();

        for (int p = 0; p < 40; p++)
        begin
            case ($urandom_range(0, 7))
                0: n = $urandom_range(13, 40);
                1: n = 2;
                default: n = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 5))
                0: pen = 0;
                1: pen = 65535;
                default: pen = $urandom_range(0, 65535);
            endcase
            set_graph_regs(n, pen);
            phase_items = 0;
            while (phase_items < 42)
            begin
                queue_run(n, pen, $urandom_range(0, 3) != 0, cnt);
                phase_items += cnt;
            end
            drain_and_settle();
        end

        $display("Checked %0d runs (%0d with a negative cycle) from %0d edge transactions.",
                 runs_done, neg_seen, edges_sent);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
